@@ hw/rtl/per_pixel_mean_sigma_image_macros.svh @@
// Assertion macros for the per-pixel mean and sigma block.
`ifndef PER_PIXEL_MEAN_SIGMA_IMAGE_MACROS_SVH
`define PER_PIXEL_MEAN_SIGMA_IMAGE_MACROS_SVH

// same-cycle implication
`define PPMS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppms assertion failed");

// next-cycle implication
`define PPMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppms assertion failed");

`endif

@@ hw/rtl/ppms_pkg.sv @@
// Package: types and constants of the per-pixel mean and sigma block.
`timescale 1ns / 1ps
package ppms_pkg;

    localparam int MAX_HEIGHT = 64;
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_FRAMES = 65536;

    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int DIM_W  = 7;
    localparam int IDX_W  = ROW_W + COL_W;
    localparam int NPIX   = MAX_HEIGHT * MAX_WIDTH;
    localparam int SUM_W  = 24;
    localparam int SQ_W   = 48;
    localparam int CNT_W  = 17;
    localparam int DEN_W  = CNT_W + 1;
    localparam int REM_W  = 35;
    localparam int ACC_W  = 40;
    localparam int QUO_W  = 16;
    localparam int DEV_W  = 16;
    localparam int DSQ_W  = 2 * DEV_W;

    localparam int CNT_HW_MAX = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] CNT_MAX =
        CNT_W'((MAX_FRAMES < CNT_HW_MAX) ? MAX_FRAMES : CNT_HW_MAX);

    // stage 0 holds the accepted beat, stages after it apply one step each
    localparam int DIV_FIRST = 2;
    localparam int DIV_LAST  = DIV_FIRST + QUO_W - 1;
    localparam int SQRT_BITS = 8;
    localparam int MEAN_STEP = DIV_LAST + 1;
    localparam int MUL_STEP  = MEAN_STEP + 1;
    localparam int ACC_STEP  = MUL_STEP + 1;
    localparam int NST       = ACC_STEP + 2;

    localparam logic [1:0] FUNC_SUM  = 2'd0;
    localparam logic [1:0] FUNC_SQ   = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    localparam logic REG_HEIGHT = 1'b0;
    localparam logic REG_WIDTH  = 1'b1;

    typedef struct packed {
        logic [1:0]       func;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [7:0]       pixel_value;
    } pix_t;

    typedef struct packed {
        logic [7:0] mean_value;
        logic [7:0] sigma_value;
        logic       no_frames;
    } res_t;

    typedef struct packed {
        logic [1:0]              func;
        logic                    in_area;
        logic                    wr;
        logic [IDX_W-1:0]        idx;
        logic [7:0]              pix;
        logic [CNT_W-1:0]        cnt;
        logic [SUM_W-1:0]        sum;
        logic [SQ_W-1:0]         sq;
        logic [REM_W-1:0]        rem;
        logic [DEN_W-1:0]        den;
        logic [QUO_W-1:0]        quo;
        logic                    qsat;
        logic signed [ACC_W-1:0] pp;
        logic signed [ACC_W-1:0] qq;
        logic [7:0]              sn;
        logic [7:0]              mv;
        logic [DEV_W-1:0]        dev;
        logic [DSQ_W-1:0]        dsq;
    } stage_t;

endpackage

@@ hw/rtl/per_pixel_mean_sigma_image.sv @@
// Top level: per-pixel mean and standard deviation over a stream of frames.
//
//  channel | signals                               | beat
//  pix     | pix_valid, pix_ready, pix_data        | func, row, col, pixel_value
//  res     | res_valid, res_ready, res_data        | mean_value, sigma_value, no_frames
//  cfg     | psel, penable, pwrite, paddr, pwdata  | image_height (0x0), image_width (0x4)
//
// One beat per cycle unless pix_ready is held low (clear, hazard, output stall); the restoring
// divider yields the 16-bit quotient one bit per stage, and the sqrt search runs alongside it.
// After reset both stores are cleared, one entry a cycle, all 4096 entries with pix_ready low.
// A beat to a pixel with a store write still in flight waits until that write retires.
// A full output register stalls the pipeline only while the last stage holds a read beat; bubbles collapse.
`timescale 1ns / 1ps
module per_pixel_mean_sigma_image (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pix_valid,
    output logic                pix_ready,
    input  ppms_pkg::pix_t      pix_data,
    output logic                res_valid,
    input  logic                res_ready,
    output ppms_pkg::res_t      res_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import ppms_pkg::*;

    localparam int L = NST - 1;

    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] width_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             clr_busy_reg;
    logic [IDX_W-1:0] clr_cnt_reg;

    logic [SUM_W-1:0] psum_mem [NPIX];
    logic [SQ_W-1:0]  sq_mem   [NPIX];

    stage_t           st_reg  [NST];
    logic [NST-1:0]   vld_reg;
    logic [NST-1:0]   adv;

    logic             res_vld_reg;
    res_t             res_reg;

    logic [DIM_W-1:0] h_use;
    logic [DIM_W-1:0] w_use;
    logic             in_inside;
    logic             in_last;
    logic [IDX_W-1:0] in_idx;
    logic             hazard;
    logic             accept;
    logic             last_is_res;
    logic             last_go;

    // ---------------- configuration ----------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= DIM_W'(MAX_HEIGHT);
            width_reg  <= DIM_W'(MAX_WIDTH);
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == REG_HEIGHT)
                height_reg <= pwdata[DIM_W-1:0];
            else
                width_reg <= pwdata[DIM_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_HEIGHT)
            prdata = {{(32-DIM_W){1'b0}}, height_reg};
        else
            prdata = {{(32-DIM_W){1'b0}}, width_reg};
    end

    // ---------------- input decode ----------------
    always_comb
    begin
        h_use = height_reg;
        if (height_reg == '0)
            h_use = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            h_use = DIM_W'(MAX_HEIGHT);
        w_use = width_reg;
        if (width_reg == '0)
            w_use = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_WIDTH))
            w_use = DIM_W'(MAX_WIDTH);
    end

    assign in_inside = ({1'b0, pix_data.row} < h_use) && ({1'b0, pix_data.col} < w_use);
    assign in_last   = ({1'b0, pix_data.row} == h_use - DIM_W'(1))
                    && ({1'b0, pix_data.col} == w_use - DIM_W'(1));
    assign in_idx    = {pix_data.row, pix_data.col};

    always_comb
    begin
        hazard = 1'b0;
        for (int k = 0; k < NST; k++)
        begin
            if (vld_reg[k] && st_reg[k].wr && st_reg[k].idx == in_idx)
                hazard = 1'b1;
        end
    end

    assign pix_ready = adv[0] && !clr_busy_reg && !(hazard && in_inside);
    assign accept    = pix_valid && pix_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (accept && pix_data.func == FUNC_SUM && in_inside && in_last
                 && cnt_reg < CNT_MAX)
            cnt_reg <= cnt_reg + CNT_W'(1);
    end

    // ---------------- pipeline control ----------------
    assign last_is_res = st_reg[L].func == FUNC_READ;
    assign last_go     = vld_reg[L] && (!last_is_res || !res_vld_reg || res_ready);

    always_comb
    begin
        adv[L] = !vld_reg[L] || last_go;
        for (int k = L - 1; k >= 0; k--)
            adv[k] = !vld_reg[k] || adv[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv[0])
                vld_reg[0] <= accept;
            for (int k = 1; k < NST; k++)
            begin
                if (adv[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // one step of work per stage
    function automatic stage_t step(input stage_t a, input int k);
        stage_t                  r;
        int                      j;
        int                      b;
        logic [REM_W-1:0]        dsh;
        logic signed [ACC_W-1:0] cext;
        logic signed [ACC_W-1:0] pc;
        logic signed [ACC_W-1:0] qc;
        logic signed [ACC_W-1:0] lim;
        logic [DEV_W-1:0]        m16;
        logic [DEV_W-1:0]        p16;
        logic [SUM_W:0]          s_add;
        logic [SQ_W:0]           q_add;
        r    = a;
        cext = $signed({{(ACC_W-CNT_W){1'b0}}, a.cnt});
        lim  = $signed({{(ACC_W-SQ_W+14){1'b0}}, a.sq[SQ_W-1:14]});
        if (k == 0)
        begin
            r.rem = {2'b0, a.sum, 9'b0}
                  + ((a.func == FUNC_READ) ? {10'b0, a.cnt, 8'b0} : {18'b0, a.cnt});
            r.den  = {a.cnt, 1'b0};
            r.quo  = '0;
            r.qsat = 1'b0;
            r.pp   = cext;
            r.qq   = -cext;
            r.sn   = '0;
        end
        if (k == 1)
            r.qsat = a.rem >= (REM_W'(a.den) << QUO_W);
        if (k >= DIV_FIRST && k <= DIV_LAST)
        begin
            j   = DIV_LAST - k;
            dsh = REM_W'(a.den) << j;
            if (a.rem >= dsh)
            begin
                r.rem    = a.rem - dsh;
                r.quo[j] = 1'b1;
            end
        end
        if (k >= 1 && k <= SQRT_BITS)
        begin
            b  = SQRT_BITS - k;
            pc = a.pp + (a.qq <<< (b + 2)) + (cext <<< (2 * b + 2));
            qc = a.qq + (cext <<< (b + 1));
            if (pc <= lim)
            begin
                r.pp    = pc;
                r.qq    = qc;
                r.sn[b] = 1'b1;
            end
        end
        if (k == MEAN_STEP)
        begin
            if (a.cnt == '0)
                m16 = '0;
            else if (a.qsat)
                m16 = '1;
            else
                m16 = a.quo;
            p16   = {a.pix, 8'b0};
            r.dev = (p16 >= m16) ? p16 - m16 : m16 - p16;
            r.mv  = a.qsat ? 8'hFF : a.quo[QUO_W-1:QUO_W-8];
        end
        if (k == MUL_STEP)
            r.dsq = a.dev * a.dev;
        if (k == ACC_STEP)
        begin
            s_add = {1'b0, a.sum} + (SUM_W+1)'(a.pix);
            r.sum = s_add[SUM_W] ? '1 : s_add[SUM_W-1:0];
            q_add = {1'b0, a.sq} + (SQ_W+1)'(a.dsq);
            r.sq  = q_add[SQ_W] ? '1 : q_add[SQ_W-1:0];
        end
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_reg[0].func <= pix_data.func;
            st_reg[0].in_area <= in_inside;
            st_reg[0].wr <= in_inside
                && (pix_data.func == FUNC_SUM || pix_data.func == FUNC_SQ);
            st_reg[0].idx  <= in_idx;
            st_reg[0].pix  <= pix_data.pixel_value;
            st_reg[0].cnt  <= cnt_reg;
            st_reg[0].sum  <= psum_mem[in_idx];
            st_reg[0].sq   <= sq_mem[in_idx];
            st_reg[0].rem  <= '0;
            st_reg[0].den  <= '0;
            st_reg[0].quo  <= '0;
            st_reg[0].qsat <= 1'b0;
            st_reg[0].pp   <= '0;
            st_reg[0].qq   <= '0;
            st_reg[0].sn   <= '0;
            st_reg[0].mv   <= '0;
            st_reg[0].dev  <= '0;
            st_reg[0].dsq  <= '0;
        end
        for (int k = 1; k < NST; k++)
        begin
            if (adv[k])
                st_reg[k] <= step(st_reg[k-1], k - 1);
        end
    end

    // ---------------- store clear and write-back ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            if (clr_cnt_reg == IDX_W'(NPIX - 1))
                clr_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            psum_mem[clr_cnt_reg] <= '0;
        else if (last_go && st_reg[L].wr && st_reg[L].func == FUNC_SUM)
            psum_mem[st_reg[L].idx] <= st_reg[L].sum;
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            sq_mem[clr_cnt_reg] <= '0;
        else if (last_go && st_reg[L].wr && st_reg[L].func == FUNC_SQ)
            sq_mem[st_reg[L].idx] <= st_reg[L].sq;
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else if (last_go && last_is_res)
            res_vld_reg <= 1'b1;
        else if (res_ready)
            res_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (last_go && last_is_res)
        begin
            res_reg.no_frames <= st_reg[L].cnt == '0;
            if (st_reg[L].in_area && st_reg[L].cnt != '0)
            begin
                res_reg.mean_value  <= st_reg[L].mv;
                res_reg.sigma_value <= st_reg[L].sn;
            end
            else
            begin
                res_reg.mean_value  <= '0;
                res_reg.sigma_value <= '0;
            end
        end
    end

    assign res_valid = res_vld_reg;
    assign res_data  = res_reg;

    // ---------------- checks ----------------
`include "per_pixel_mean_sigma_image_macros.svh"

    `PPMS_ASSERT_NOW(a_no_accept_in_clear, clr_busy_reg, !pix_ready)
    `PPMS_ASSERT_NOW(a_cnt_bounded, 1'b1, cnt_reg <= CNT_MAX)
    `PPMS_ASSERT_NOW(a_retire_slot_free, last_go && last_is_res, !res_vld_reg || res_ready)
    `PPMS_ASSERT_NEXT(a_accept_enters, accept, vld_reg[0])

endmodule
